// File: rtl/gobl_pkg.sv
package gobl_pkg;

   localparam int RAW_W      = 16;
   localparam int COEF_W     = 24;
   localparam int OUT_W      = 24;
   localparam int MAX_AXES   = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam int AXES_DEF           = 3;
   localparam int COEF_FRAC_BITS_DEF = 22;
   localparam int OUT_FRAC_BITS_DEF  = 8;

   localparam int OUT_MAX = 8388607;
   localparam int OUT_MIN = -8388608;

   localparam logic [CSR_IDX_W-1:0] REG_COEF_B0  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_B1  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_B2  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_A1  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_A2  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_X = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_Y = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_Z = 3'd7;

   // 30 Hz butterworth at 200 Hz sample rate, q2.22
   localparam logic signed [COEF_W-1:0] COEF_B0_RST = 24'sd549900;
   localparam logic signed [COEF_W-1:0] COEF_B1_RST = 24'sd1099801;
   localparam logic signed [COEF_W-1:0] COEF_B2_RST = 24'sd549900;
   localparam logic signed [COEF_W-1:0] COEF_A1_RST = -24'sd3136455;
   localparam logic signed [COEF_W-1:0] COEF_A2_RST = 24'sd1141752;

   typedef struct packed {
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] b2;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
   } coef_set_type;

   typedef struct packed {
      logic load1;
      logic load2;
      logic load3;
   } pipe_ctrl_type;

   typedef struct packed {
      logic signed [RAW_W-1:0] raw_x;
      logic signed [RAW_W-1:0] raw_y;
      logic signed [RAW_W-1:0] raw_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] filt_x;
      logic signed [OUT_W-1:0] filt_y;
      logic signed [OUT_W-1:0] filt_z;
   } rsp_payload_type;

endpackage

// File: rtl/gobl_stream_if.sv
interface gobl_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/gobl_pipe_ctrl.sv
module gobl_pipe_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   output logic                   out_valid,
   input  logic                   out_ready,
   output gobl_pkg::pipe_ctrl_type ctrl
);
   import gobl_pkg::*;

   logic v1_ff, v2_ff, v3_ff;
   logic v1_in, v2_in, v3_in;
   logic ready1, ready2, ready3;

   // each stage moves when the one after it is empty or moving
   assign ready3     = !v3_ff || out_ready;
   assign ctrl.load3 = v2_ff && ready3;
   assign ready2     = !v2_ff || ctrl.load3;
   assign ctrl.load2 = v1_ff && ready2;
   assign ready1     = !v1_ff || ctrl.load2;
   assign ctrl.load1 = in_valid && ready1;

   assign in_ready  = ready1;
   assign out_valid = v3_ff;

   assign v1_in = ctrl.load1 || (v1_ff && !ctrl.load2);
   assign v2_in = ctrl.load2 || (v2_ff && !ctrl.load3);
   assign v3_in = ctrl.load3 || (v3_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

endmodule

// File: rtl/gobl_lane.sv
module gobl_lane #(
   parameter int COEF_FRAC_BITS = gobl_pkg::COEF_FRAC_BITS_DEF,
   parameter int OUT_FRAC_BITS  = gobl_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  gobl_pkg::pipe_ctrl_type             ctrl,
   input  gobl_pkg::coef_set_type              coef,
   input  logic signed [gobl_pkg::RAW_W-1:0]   offset,
   input  logic signed [gobl_pkg::RAW_W-1:0]   raw,
   output logic signed [gobl_pkg::OUT_W-1:0]   filt
);
   import gobl_pkg::*;

   localparam int PROD_W = COEF_W + RAW_W;
   localparam int FB_W   = COEF_W + OUT_W;
   localparam int FF_W   = PROD_W + 2 + OUT_FRAC_BITS;
   localparam int ACC_W  = ((FF_W > FB_W + 1) ? FF_W : FB_W + 1) + 1;

   localparam logic signed [ACC_W-1:0] HALF =
      {{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
   localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(OUT_MAX);
   localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(OUT_MIN);

   // input history and feedforward products
   logic signed [RAW_W-1:0]  x0;
   logic signed [RAW_W-1:0]  x1_ff, x2_ff;
   logic signed [PROD_W-1:0] p0_in, p1_in, p2_in;
   logic signed [PROD_W-1:0] p0_ff, p1_ff, p2_ff;

   // feedforward sum with rounding constant
   logic signed [ACC_W-1:0]  s_in, s_ff;

   // feedback
   logic signed [OUT_W-1:0]  y1_ff, y2_ff;
   logic signed [OUT_W-1:0]  y2_next;
   logic signed [FB_W-1:0]   fb_prod;
   logic signed [FB_W-1:0]   ap_in, ap_ff;
   logic signed [ACC_W-1:0]  acc;
   logic signed [ACC_W-1:0]  shifted;
   logic signed [OUT_W-1:0]  y_in;

   assign x0    = raw - offset;
   assign p0_in = coef.b0 * x0;
   assign p1_in = coef.b1 * x1_ff;
   assign p2_in = coef.b2 * x2_ff;

   assign s_in = ((ACC_W'(p0_ff) + ACC_W'(p1_ff) + ACC_W'(p2_ff)) <<< OUT_FRAC_BITS) + HALF;

   // a2 term is registered ahead from the value y2 will hold next
   assign y2_next = ctrl.load3 ? y1_ff : y2_ff;
   assign ap_in   = coef.a2 * y2_next;

   assign fb_prod = coef.a1 * y1_ff;
   assign acc     = s_ff - ACC_W'(fb_prod) - ACC_W'(ap_ff);
   assign shifted = acc >>> COEF_FRAC_BITS;

   always_comb begin
      if (shifted > SAT_MAX) begin
         y_in = OUT_W'(SAT_MAX);
      end else if (shifted < SAT_MIN) begin
         y_in = OUT_W'(SAT_MIN);
      end else begin
         y_in = shifted[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff <= '0;
         x2_ff <= '0;
         y1_ff <= '0;
         y2_ff <= '0;
         ap_ff <= '0;
      end else begin
         ap_ff <= ap_in;
         if (ctrl.load1) begin
            x1_ff <= x0;
            x2_ff <= x1_ff;
         end
         if (ctrl.load3) begin
            y1_ff <= y_in;
            y2_ff <= y1_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load1) begin
         p0_ff <= p0_in;
         p1_ff <= p1_in;
         p2_ff <= p2_in;
      end
      if (ctrl.load2) begin
         s_ff <= s_in;
      end
   end

   // the latest output doubles as the result register
   assign filt = y1_ff;

endmodule

// File: rtl/gyro_offset_biquad_lowpass_3axis_core.sv
// channel   dir  fields                        width        transfer
// req_ch    in   raw_x, raw_y, raw_z           3 x 16 s     valid && ready
// rsp_ch    out  filt_x, filt_y, filt_z        3 x 24 s     valid && ready
// csr_*     in   coef_b0..coef_a2, offset_x..z 24 / 16 s    csr_we, no read-back
//
// one sample per cycle sustained while rsp_ch is ready; a result passes
// through the product, feedforward sum and feedback stage registers in turn
// and can transfer out once it reaches the output register.
// the rate is set by the per-axis feedback stage: one a1*y1 multiply, sum,
// round and saturate per cycle, with the a2*y2 product registered beforehand.
// synchronous reset clears the valid bits and all filter history to zero.
// a stalled result holds in the output register while earlier stages keep filling.
module gyro_offset_biquad_lowpass_3axis_core #(
   parameter int AXES           = gobl_pkg::AXES_DEF,
   parameter int COEF_FRAC_BITS = gobl_pkg::COEF_FRAC_BITS_DEF,
   parameter int OUT_FRAC_BITS  = gobl_pkg::OUT_FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   gobl_stream_if.sink                          req_ch,
   gobl_stream_if.source                        rsp_ch,
   input  logic                                 csr_we,
   input  logic [gobl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [gobl_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import gobl_pkg::*;

   coef_set_type            coef_ff;
   logic signed [RAW_W-1:0] offset_ff [MAX_AXES];
   pipe_ctrl_type           ctrl;
   logic signed [RAW_W-1:0] raw_axis  [MAX_AXES];
   logic signed [OUT_W-1:0] filt_axis [MAX_AXES];

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff.b0   <= COEF_B0_RST;
         coef_ff.b1   <= COEF_B1_RST;
         coef_ff.b2   <= COEF_B2_RST;
         coef_ff.a1   <= COEF_A1_RST;
         coef_ff.a2   <= COEF_A2_RST;
         offset_ff[0] <= '0;
         offset_ff[1] <= '0;
         offset_ff[2] <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_COEF_B0:  coef_ff.b0   <= csr_wdata[COEF_W-1:0];
            REG_COEF_B1:  coef_ff.b1   <= csr_wdata[COEF_W-1:0];
            REG_COEF_B2:  coef_ff.b2   <= csr_wdata[COEF_W-1:0];
            REG_COEF_A1:  coef_ff.a1   <= csr_wdata[COEF_W-1:0];
            REG_COEF_A2:  coef_ff.a2   <= csr_wdata[COEF_W-1:0];
            REG_OFFSET_X: offset_ff[0] <= csr_wdata[RAW_W-1:0];
            REG_OFFSET_Y: offset_ff[1] <= csr_wdata[RAW_W-1:0];
            REG_OFFSET_Z: offset_ff[2] <= csr_wdata[RAW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   gobl_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .ctrl      (ctrl)
   );

   assign raw_axis[0] = req_ch.payload.raw_x;
   assign raw_axis[1] = req_ch.payload.raw_y;
   assign raw_axis[2] = req_ch.payload.raw_z;

   for (genvar a = 0; a < MAX_AXES; a++) begin : g_lane
      if (a < AXES) begin : g_on
         gobl_lane #(
            .COEF_FRAC_BITS (COEF_FRAC_BITS),
            .OUT_FRAC_BITS  (OUT_FRAC_BITS)
         ) u_lane (
            .clock  (clock),
            .reset  (reset),
            .ctrl   (ctrl),
            .coef   (coef_ff),
            .offset (offset_ff[a]),
            .raw    (raw_axis[a]),
            .filt   (filt_axis[a])
         );
      end else begin : g_off
         // axis not built: reads as zero
         assign filt_axis[a] = '0;
      end
   end

   // merge lane results into one response
   assign rsp_ch.payload.filt_x = filt_axis[0];
   assign rsp_ch.payload.filt_y = filt_axis[1];
   assign rsp_ch.payload.filt_z = filt_axis[2];

endmodule
